/* design/utrb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utrb_pkg
// shared constants and types of the uart transmit/receive ring buffer core
// ----------------------------------------------------------------------------
package utrb_pkg;

	localparam int RING_DEPTH = 1024;
	localparam int ADDR_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);
	localparam int BYTE_W     = 8;
	localparam int LEVEL_W    = 11;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_EVENT = 2'd2
	} cmd_t;

	typedef logic [ADDR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	function automatic ptr_t next_ptr(input ptr_t p);
		return (p == ptr_t'(RING_DEPTH - 1)) ? '0 : p + ptr_t'(1);
	endfunction

endpackage
`default_nettype wire

/* design/utrb_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utrb_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module utrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* design/uart_tx_rx_ring_buffers_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uart_tx_rx_ring_buffers_core
// transmit and receive byte rings of an interrupt driven uart driver
// ----------------------------------------------------------------------------
// a request loads stage 1 together with the ram read at the accepting edge, then
// moves into the output register once that register is empty or not stalled
// throughput: one request per cycle, set by the single read and write port
// of each ring ram; input stalls only while stage 1 and the output are both
// full and the output is stalled
// reset: arst_n clears pointers, levels, interrupt enable and valid flags;
// ram contents are left as they are and no stale entry is ever read
module uart_tx_rx_ring_buffers_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [1:0]                  cmd,
	input  wire logic [utrb_pkg::BYTE_W-1:0] data_byte,
	input  wire logic                        last,
	input  wire logic                        rx_ready,
	input  wire logic [utrb_pkg::BYTE_W-1:0] rx_byte,
	input  wire logic                        tx_empty,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             tx_valid,
	output logic [utrb_pkg::BYTE_W-1:0]      tx_byte,
	output logic                             read_valid,
	output logic [utrb_pkg::BYTE_W-1:0]      read_byte,
	output logic                             request_done,
	output logic [utrb_pkg::LEVEL_W-1:0]     rx_level,
	output logic                             tx_irq_enable,
	output logic                             overflow
);

	utrb_pkg::ptr_t tx_head_q, tx_tail_q, rx_head_q, rx_tail_q;
	utrb_pkg::cnt_t tx_level_q, rx_count_q;
	logic           tie_q;

	logic valid_s1, txv_s1, rdv_s1, done_s1, tie_s1, ovf_s1;
	utrb_pkg::cnt_t level_s1;

	logic [utrb_pkg::BYTE_W-1:0] tx_rdata, rx_rdata;

	logic acc, s1_move;
	logic is_wr, is_rd, is_ev;
	logic tx_full, rx_full, tx_push, rx_push, tx_pop, rx_pop;
	logic tie_next, done_next;
	utrb_pkg::cnt_t rx_count_next;

	assign in_stall = valid_s1 && out_valid && out_stall;
	assign acc      = in_valid && !in_stall;
	assign s1_move  = valid_s1 && !(out_valid && out_stall);

	assign is_wr = (cmd == utrb_pkg::CMD_WRITE);
	assign is_rd = (cmd == utrb_pkg::CMD_READ);
	assign is_ev = (cmd == utrb_pkg::CMD_EVENT);

	assign tx_full = (tx_level_q == utrb_pkg::cnt_t'(utrb_pkg::RING_DEPTH));
	assign rx_full = (rx_count_q == utrb_pkg::cnt_t'(utrb_pkg::RING_DEPTH));

	assign tx_push = is_wr && !tx_full;
	assign rx_push = is_ev && rx_ready && !rx_full;
	assign tx_pop  = is_ev && tx_empty && (tx_level_q != '0);
	assign rx_pop  = is_rd && (rx_count_q != '0);

	always_comb begin
		tie_next = tie_q;
		if (is_wr && last) begin
			tie_next = 1'b1;
		end
		if (is_ev && tx_empty && (tx_level_q <= utrb_pkg::cnt_t'(1))) begin
			tie_next = 1'b0;
		end
	end

	always_comb begin
		if (is_wr) begin
			done_next = last;
		end else if (is_rd) begin
			done_next = (rx_count_q == '0) ? 1'b1 : last;
		end else begin
			done_next = 1'b0;
		end
	end

	// push and pop of one ring never come with the same command
	always_comb begin
		rx_count_next = rx_count_q;
		if (rx_push) begin
			rx_count_next = rx_count_q + utrb_pkg::cnt_t'(1);
		end else if (rx_pop) begin
			rx_count_next = rx_count_q - utrb_pkg::cnt_t'(1);
		end
	end

	utrb_ram #(
		.WIDTH(utrb_pkg::BYTE_W),
		.DEPTH(utrb_pkg::RING_DEPTH)
	) u_tx_ram (
		.clk  (clk),
		.we   (acc && tx_push),
		.waddr(tx_head_q),
		.wdata(data_byte),
		.re   (acc && tx_pop),
		.raddr(tx_tail_q),
		.rdata(tx_rdata)
	);

	utrb_ram #(
		.WIDTH(utrb_pkg::BYTE_W),
		.DEPTH(utrb_pkg::RING_DEPTH)
	) u_rx_ram (
		.clk  (clk),
		.we   (acc && rx_push),
		.waddr(rx_head_q),
		.wdata(rx_byte),
		.re   (acc && rx_pop),
		.raddr(rx_tail_q),
		.rdata(rx_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_head_q  <= '0;
			tx_tail_q  <= '0;
			tx_level_q <= '0;
			rx_head_q  <= '0;
			rx_tail_q  <= '0;
			rx_count_q <= '0;
			tie_q      <= 1'b0;
		end else if (acc) begin
			if (tx_push) begin
				tx_head_q  <= utrb_pkg::next_ptr(tx_head_q);
				tx_level_q <= tx_level_q + utrb_pkg::cnt_t'(1);
			end else if (tx_pop) begin
				tx_tail_q  <= utrb_pkg::next_ptr(tx_tail_q);
				tx_level_q <= tx_level_q - utrb_pkg::cnt_t'(1);
			end
			if (rx_push) begin
				rx_head_q <= utrb_pkg::next_ptr(rx_head_q);
			end
			if (rx_pop) begin
				rx_tail_q <= utrb_pkg::next_ptr(rx_tail_q);
			end
			rx_count_q <= rx_count_next;
			tie_q      <= tie_next;
		end
	end

	// stage 1 waits for the ram read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			txv_s1   <= tx_pop;
			rdv_s1   <= rx_pop;
			done_s1  <= done_next;
			tie_s1   <= tie_next;
			ovf_s1   <= (is_wr && tx_full) || (is_ev && rx_ready && rx_full);
			level_s1 <= rx_count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_move) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			tx_valid      <= txv_s1;
			tx_byte       <= txv_s1 ? tx_rdata : '0;
			read_valid    <= rdv_s1;
			read_byte     <= rdv_s1 ? rx_rdata : '0;
			request_done  <= done_s1;
			rx_level      <= utrb_pkg::LEVEL_W'(level_s1);
			tx_irq_enable <= tie_s1;
			overflow      <= ovf_s1;
		end
	end

	a_tx_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tx_level_q <= utrb_pkg::cnt_t'(utrb_pkg::RING_DEPTH))
		else $error("transmit level above ring depth");

	a_rx_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rx_count_q <= utrb_pkg::cnt_t'(utrb_pkg::RING_DEPTH))
		else $error("receive count above ring depth");

	a_full_write_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_wr && tx_full) |=> (tx_level_q == $past(tx_level_q)
			&& tx_head_q == $past(tx_head_q)))
		else $error("write into full transmit ring changed the ring");

	a_stage_not_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_move) |=> valid_s1)
		else $error("stage 1 request dropped while output was stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(rx_level)
			&& $stable(tx_byte) && $stable(read_byte)))
		else $error("stalled result changed");

endmodule
`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks uart_tx_rx_ring_buffers_core against a cycle-free ring predictor:
// a directed table first, then random phases that mix all commands, fill the transmit ring,
// load the receive ring and then take bytes from both
// ----------------------------------------------------------------------------
module testbench;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]                  cmd;
		logic [utrb_pkg::BYTE_W-1:0] data_byte;
		logic                        last;
		logic                        rx_ready;
		logic [utrb_pkg::BYTE_W-1:0] rx_byte;
		logic                        tx_empty;
	} uart_req_t;

	typedef struct packed {
		logic                         tx_valid;
		logic [utrb_pkg::BYTE_W-1:0]  tx_byte;
		logic                         read_valid;
		logic [utrb_pkg::BYTE_W-1:0]  read_byte;
		logic                         request_done;
		logic [utrb_pkg::LEVEL_W-1:0] rx_level;
		logic                         tx_irq_enable;
		logic                         overflow;
	} uart_rsp_t;

	typedef struct packed {
		uart_req_t req;
		logic      typed;
		uart_rsp_t rsp;
	} table_entry_t;

	typedef enum int {PH_MIX, PH_TX_FILL, PH_RX_FILL, PH_DRAIN} phase_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [1:0]                  cmd = utrb_pkg::CMD_WRITE;
	logic [utrb_pkg::BYTE_W-1:0] data_byte = '0;
	logic                        last = 1'b0;
	logic                        rx_ready = 1'b0;
	logic [utrb_pkg::BYTE_W-1:0] rx_byte = '0;
	logic                        tx_empty = 1'b0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic                         tx_valid;
	logic [utrb_pkg::BYTE_W-1:0]  tx_byte;
	logic                         read_valid;
	logic [utrb_pkg::BYTE_W-1:0]  read_byte;
	logic                         request_done;
	logic [utrb_pkg::LEVEL_W-1:0] rx_level;
	logic                         tx_irq_enable;
	logic                         overflow;

	// predictor state
	logic [utrb_pkg::BYTE_W-1:0] tx_ring [utrb_pkg::RING_DEPTH];
	logic [utrb_pkg::BYTE_W-1:0] rx_ring [utrb_pkg::RING_DEPTH];
	int unsigned       tx_wr = 0, tx_rd = 0, tx_cnt = 0;
	int unsigned       rx_wr = 0, rx_rd = 0, rx_cnt = 0;
	logic              irq_en = 1'b0;

	uart_rsp_t    awaited_rsp [$];
	table_entry_t stim_table [$];
	int unsigned  err_count = 0;
	int unsigned  sent = 0;
	int unsigned  send_idle = 22;
	int unsigned  recv_idle = 64;
	int unsigned  hold_left = 0;

	uart_tx_rx_ring_buffers_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.data_byte(data_byte),
		.last(last),
		.rx_ready(rx_ready),
		.rx_byte(rx_byte),
		.tx_empty(tx_empty),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.tx_valid(tx_valid),
		.tx_byte(tx_byte),
		.read_valid(read_valid),
		.read_byte(read_byte),
		.request_done(request_done),
		.rx_level(rx_level),
		.tx_irq_enable(tx_irq_enable),
		.overflow(overflow)
	);

	always #4 clk = ~clk;

	initial begin : watchdog
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic uart_rsp_t uart_ring_step(input uart_req_t r);
		uart_rsp_t o;
		o = '0;
		case (r.cmd)
			utrb_pkg::CMD_WRITE: begin
				if (tx_cnt >= utrb_pkg::RING_DEPTH) begin
					o.overflow = 1'b1;
				end else begin
					tx_ring[tx_wr] = r.data_byte;
					tx_wr = (tx_wr + 1) % utrb_pkg::RING_DEPTH;
					tx_cnt++;
				end
				// a dropped last byte still arms the interrupt
				if (r.last)
					irq_en = 1'b1;
				o.request_done = r.last;
			end
			utrb_pkg::CMD_READ: begin
				if (rx_cnt > 0) begin
					o.read_byte = rx_ring[rx_rd];
					o.read_valid = 1'b1;
					rx_rd = (rx_rd + 1) % utrb_pkg::RING_DEPTH;
					rx_cnt--;
					o.request_done = r.last;
				end else begin
					o.request_done = 1'b1;
				end
			end
			utrb_pkg::CMD_EVENT: begin
				if (r.rx_ready) begin
					if (rx_cnt >= utrb_pkg::RING_DEPTH) begin
						o.overflow = 1'b1;
					end else begin
						rx_ring[rx_wr] = r.rx_byte;
						rx_wr = (rx_wr + 1) % utrb_pkg::RING_DEPTH;
						rx_cnt++;
					end
				end
				if (r.tx_empty) begin
					if (tx_cnt <= 1)
						irq_en = 1'b0;
					if (tx_cnt > 0) begin
						o.tx_byte = tx_ring[tx_rd];
						o.tx_valid = 1'b1;
						tx_rd = (tx_rd + 1) % utrb_pkg::RING_DEPTH;
						tx_cnt--;
					end
				end
			end
			default: ;
		endcase
		o.rx_level = utrb_pkg::LEVEL_W'(rx_cnt);
		o.tx_irq_enable = irq_en;
		return o;
	endfunction

	function automatic uart_rsp_t result_of(input int txv, input int txb,
			input int rdv, input int rdb, input int done,
			input int lvl, input int tie, input int ovf);
		return '{1'(txv), 8'(txb), 1'(rdv), 8'(rdb), 1'(done),
			utrb_pkg::LEVEL_W'(lvl), 1'(tie), 1'(ovf)};
	endfunction

	function automatic table_entry_t table_entry(input logic [1:0] c, input logic [7:0] d,
			input logic l, input logic rr, input logic [7:0] rb, input logic te,
			input logic typed, input uart_rsp_t want);
		return '{'{c, d, l, rr, rb, te}, typed, want};
	endfunction

	function automatic uart_req_t random_request(input phase_t ph);
		uart_req_t   r;
		int unsigned pick;
		r.cmd = utrb_pkg::CMD_EVENT;
		r.data_byte = utrb_pkg::BYTE_W'($urandom);
		r.last = 1'($urandom);
		r.rx_ready = 1'($urandom);
		r.rx_byte = utrb_pkg::BYTE_W'($urandom);
		r.tx_empty = 1'($urandom);
		pick = $urandom_range(99);
		case (ph)
			PH_MIX: begin
				if (pick < 30)
					r.cmd = utrb_pkg::CMD_WRITE;
				else if (pick < 55)
					r.cmd = utrb_pkg::CMD_READ;
				else if (pick < 95)
					r.cmd = utrb_pkg::CMD_EVENT;
				else
					r.cmd = CMD_UNUSED;
			end
			PH_TX_FILL: begin
				if (pick < 97) begin
					r.cmd = utrb_pkg::CMD_WRITE;
				end else if (pick < 99) begin
					r.cmd = utrb_pkg::CMD_EVENT;
					r.tx_empty = 1'b0;
				end else begin
					r.cmd = utrb_pkg::CMD_READ;
				end
			end
			PH_RX_FILL: begin
				if (pick < 96) begin
					r.cmd = utrb_pkg::CMD_EVENT;
					r.rx_ready = 1'b1;
					r.tx_empty = ($urandom_range(99) < 60);
				end else if (pick < 98) begin
					r.cmd = utrb_pkg::CMD_WRITE;
				end else begin
					r.cmd = utrb_pkg::CMD_READ;
				end
			end
			default: begin
				if (pick < 50) begin
					r.cmd = utrb_pkg::CMD_READ;
				end else if (pick < 95) begin
					r.cmd = utrb_pkg::CMD_EVENT;
					r.tx_empty = ($urandom_range(9) != 0);
				end else begin
					r.cmd = utrb_pkg::CMD_WRITE;
				end
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		if (err_count < 100)
			$display("mismatch %s: got %0h, expected %0h", what, got, want);
		err_count++;
	endtask

	task automatic send_request(input uart_req_t r, input logic typed, input uart_rsp_t want);
		uart_rsp_t predicted;
		if (sent < 600) begin
			send_idle = 22;
			recv_idle = 64;
		end else if (sent < 1200) begin
			send_idle = 64;
			recv_idle = 22;
		end else begin
			send_idle = 0;
			recv_idle = 0;
		end
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= r.cmd;
		data_byte <= r.data_byte;
		last <= r.last;
		rx_ready <= r.rx_ready;
		rx_byte <= r.rx_byte;
		tx_empty <= r.tx_empty;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = uart_ring_step(r);
		awaited_rsp.push_back(typed ? want : predicted);
		sent++;
	endtask

	// receiver: random stalls, plus a long hold-off when asked
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	always @(posedge clk) begin : check_results
		uart_rsp_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_rsp.size() == 0) begin
				report_mismatch("result with no request pending", 32'(rx_level), 0);
			end else begin
				want = awaited_rsp.pop_front();
				if (tx_valid !== want.tx_valid)
					report_mismatch("tx_valid", 32'(tx_valid), 32'(want.tx_valid));
				if (tx_byte !== want.tx_byte)
					report_mismatch("tx_byte", 32'(tx_byte), 32'(want.tx_byte));
				if (read_valid !== want.read_valid)
					report_mismatch("read_valid", 32'(read_valid), 32'(want.read_valid));
				if (read_byte !== want.read_byte)
					report_mismatch("read_byte", 32'(read_byte), 32'(want.read_byte));
				if (request_done !== want.request_done)
					report_mismatch("request_done", 32'(request_done),
						32'(want.request_done));
				if (rx_level !== want.rx_level)
					report_mismatch("rx_level", 32'(rx_level), 32'(want.rx_level));
				if (tx_irq_enable !== want.tx_irq_enable)
					report_mismatch("tx_irq_enable", 32'(tx_irq_enable),
						32'(want.tx_irq_enable));
				if (overflow !== want.overflow)
					report_mismatch("overflow", 32'(overflow), 32'(want.overflow));
			end
		end
	end

	initial begin : stimulus
		int     i;
		int     p;
		int     n;
		phase_t ph;

		// read and transmit-empty on empty rings, unused command
		stim_table.push_back(table_entry(utrb_pkg::CMD_READ, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0,
			1'b1, result_of(0, 8'h00, 0, 8'h00, 1, 0, 0, 0)));
		stim_table.push_back(table_entry(utrb_pkg::CMD_EVENT, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1,
			1'b1, result_of(0, 8'h00, 0, 8'h00, 0, 0, 0, 0)));
		stim_table.push_back(table_entry(CMD_UNUSED, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1,
			1'b1, result_of(0, 8'h00, 0, 8'h00, 0, 0, 0, 0)));
		// writes ignore the event bits
		stim_table.push_back(table_entry(utrb_pkg::CMD_WRITE, 8'h00, 1'b0, 1'b1, 8'hFF, 1'b1,
			1'b1, result_of(0, 8'h00, 0, 8'h00, 0, 0, 0, 0)));
		stim_table.push_back(table_entry(utrb_pkg::CMD_WRITE, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0,
			1'b1, result_of(0, 8'h00, 0, 8'h00, 1, 0, 1, 0)));
		// two queued: irq stays on, then the last byte clears it
		stim_table.push_back(table_entry(utrb_pkg::CMD_EVENT, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b1,
			1'b1, result_of(1, 8'h00, 0, 8'h00, 0, 0, 1, 0)));
		stim_table.push_back(table_entry(utrb_pkg::CMD_EVENT, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1,
			1'b1, result_of(1, 8'hFF, 0, 8'h00, 0, 0, 0, 0)));
		stim_table.push_back(table_entry(utrb_pkg::CMD_EVENT, 8'h00, 1'b0, 1'b1, 8'hFF, 1'b0,
			1'b1, result_of(0, 8'h00, 0, 8'h00, 0, 1, 0, 0)));
		stim_table.push_back(table_entry(utrb_pkg::CMD_EVENT, 8'h00, 1'b0, 1'b1, 8'h00, 1'b1,
			1'b1, result_of(0, 8'h00, 0, 8'h00, 0, 2, 0, 0)));
		stim_table.push_back(table_entry(utrb_pkg::CMD_WRITE, 8'hA5, 1'b1, 1'b1, 8'h11, 1'b1,
			1'b1, result_of(0, 8'h00, 0, 8'h00, 1, 2, 1, 0)));
		// event with no event bits does nothing
		stim_table.push_back(table_entry(utrb_pkg::CMD_EVENT, 8'h3C, 1'b1, 1'b0, 8'h77, 1'b0,
			1'b1, result_of(0, 8'h00, 0, 8'h00, 0, 2, 1, 0)));
		stim_table.push_back(table_entry(utrb_pkg::CMD_READ, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0,
			1'b1, result_of(0, 8'h00, 1, 8'hFF, 0, 1, 1, 0)));
		stim_table.push_back(table_entry(utrb_pkg::CMD_READ, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0,
			1'b1, result_of(0, 8'h00, 1, 8'h00, 1, 0, 1, 0)));
		stim_table.push_back(table_entry(utrb_pkg::CMD_READ, 8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1,
			1'b1, result_of(0, 8'h00, 0, 8'h00, 1, 0, 1, 0)));
		// receive and transmit halves in one event
		stim_table.push_back(table_entry(utrb_pkg::CMD_EVENT, 8'h00, 1'b0, 1'b1, 8'h5A, 1'b1,
			1'b1, result_of(1, 8'hA5, 0, 8'h00, 0, 1, 0, 0)));
		stim_table.push_back(table_entry(CMD_UNUSED, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1,
			1'b1, result_of(0, 8'h00, 0, 8'h00, 0, 1, 0, 0)));
		stim_table.push_back(table_entry(utrb_pkg::CMD_WRITE, 8'h81, 1'b1, 1'b0, 8'h00, 1'b0,
			1'b0, '0));
		stim_table.push_back(table_entry(utrb_pkg::CMD_WRITE, 8'h7E, 1'b0, 1'b1, 8'h42, 1'b0,
			1'b0, '0));
		stim_table.push_back(table_entry(utrb_pkg::CMD_WRITE, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1,
			1'b0, '0));
		stim_table.push_back(table_entry(utrb_pkg::CMD_EVENT, 8'h00, 1'b0, 1'b1, 8'h42, 1'b1,
			1'b0, '0));
		stim_table.push_back(table_entry(utrb_pkg::CMD_READ, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0,
			1'b0, '0));
		stim_table.push_back(table_entry(utrb_pkg::CMD_READ, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0,
			1'b0, '0));
		stim_table.push_back(table_entry(utrb_pkg::CMD_EVENT, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b1,
			1'b0, '0));
		stim_table.push_back(table_entry(utrb_pkg::CMD_EVENT, 8'h00, 1'b0, 1'b1, 8'hC3, 1'b1,
			1'b0, '0));
		stim_table.push_back(table_entry(utrb_pkg::CMD_READ, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0,
			1'b0, '0));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < stim_table.size(); i++)
			send_request(stim_table[i].req, stim_table[i].typed, stim_table[i].rsp);

		for (p = 0; p < 4; p++) begin
			ph = phase_t'(p);
			case (ph)
				PH_MIX:     n = 150;
				PH_TX_FILL: n = 1100;
				PH_RX_FILL: n = 430;
				default:    n = 100;
			endcase
			if (ph == PH_TX_FILL || ph == PH_RX_FILL) begin
				// let the block drain completely before the next phase
				in_valid <= 1'b0;
				while (awaited_rsp.size() != 0)
					@(posedge clk);
			end
			// long receiver hold-off so the block backs up into its input
			if (ph == PH_TX_FILL)
				hold_left = 150;
			for (i = 0; i < n; i++)
				send_request(random_request(ph), 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (err_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* uart_tx_rx_ring_buffers_core.f */
design/utrb_pkg.sv
design/utrb_ram.sv
design/uart_tx_rx_ring_buffers_core.sv
bench/testbench.sv
